FILE: rtl/depth_pixel_backprojection_assert.svh
// Assertion macros for the depth pixel back-projection checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define DPB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpb_checker: same-cycle property violated");

// Next-cycle implication, disabled while in reset
`define DPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpb_checker: next-cycle property violated");

`endif

FILE: rtl/dpb_pkg.sv
// Shared constants and types for the depth pixel back-projection block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

  // Field widths
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CTR_W      = PIX_W + FRAC_W;  // Q12.8 centre
  localparam int unsigned INV_W      = 32;              // Q0.32 reciprocal
  localparam int unsigned INV_HALF_W = INV_W / 2;
  localparam int unsigned COORD_W    = 32;              // Q23.8 output
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Datapath widths
  localparam int unsigned MAG_W  = CTR_W;                 // |u*256 - cx|
  localparam int unsigned PROD_W = MAG_W + DEPTH_W;       // |d| * z
  localparam int unsigned PART_W = PROD_W + INV_HALF_W;   // partial product
  localparam int unsigned QUO_W  = PART_W + 1 - INV_HALF_W;

  // Register reset values
  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd100;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd30000;

  // Saturation limits
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  // Configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INV_FOCAL_X  = 3'd0,
    REG_INV_FOCAL_Y  = 3'd1,
    REG_CENTRE_X     = 3'd2,
    REG_CENTRE_Y     = 3'd3,
    REG_MIN_DEPTH_MM = 3'd4,
    REG_MAX_DEPTH_MM = 3'd5,
    REG_USE_MASK     = 3'd6
  } cfg_idx_e;

  // Per-axis payload at each pipeline stage
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } axis_s1_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] prod;
  } axis_s2_t;

  typedef struct packed {
    logic              neg;
    logic [PART_W-1:0] hi;
    logic [PART_W-1:0] lo;
  } axis_s3_t;

  typedef struct packed {
    logic             neg;
    logic [QUO_W-1:0] quo;
  } axis_s4_t;

  // Per-pixel flags and depth carried alongside
  typedef struct packed {
    logic               ok;
    logic [DEPTH_W-1:0] z;
  } pix_side_t;

endpackage

`default_nettype wire

FILE: rtl/dpb_if.sv
// Valid/ready channel interfaces: configuration writes, pixel input, point output.
// Depends on dpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dpb_cfg_if
  import dpb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

interface dpb_pixel_if
  import dpb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth;
  logic [MASK_W-1:0]  mask_value;
  logic               mask_valid;
  logic [PIX_W-1:0]   pixel_col;
  logic [PIX_W-1:0]   pixel_row;

  modport source (output valid, output depth, output mask_value, output mask_valid,
                  output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input depth, input mask_value, input mask_valid,
                input pixel_col, input pixel_row, output ready);
endinterface

interface dpb_point_if
  import dpb_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [DEPTH_W-1:0]        point_z;
  logic                      point_valid;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output point_valid, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input point_valid, output ready);
endinterface

`default_nettype wire

FILE: rtl/depth_pixel_backprojection.sv
// Pinhole back-projection of a depth pixel stream: five-stage pipeline.
// Depends on dpb_pkg and the channel interfaces in dpb_if.sv.
//
// One pixel beat is taken per clock while the point side does not stall; its
// point beat passes the stages in order (input stage, |d|*z multiply, two 36x16
// partial products against the split Q0.32 reciprocal, partial-product merge,
// saturation into the output register). Each stage holds its beat only while
// the stage after it is full, so a stall on the point side fills the pipeline
// before the pixel side sees ready low, and no beat is lost or repeated. While
// either reciprocal register is zero, pixel beats are accepted and dropped
// without a point beat. A rejected pixel (valid zero mask byte with masking on,
// no depth, depth outside the range) still yields a point beat with point_valid
// low and all coordinates zero. Configuration writes are always ready and take
// effect the next cycle; they are meant to be made while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_backprojection
  import dpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dpb_cfg_if.sink     cfg_i,
  dpb_pixel_if.sink   pix_i,
  dpb_point_if.source pt_o
);

  // ---------------------------------------------------------------------------
  // Helpers

  // Signed distance of a pixel from the principal point, as sign and magnitude
  function automatic axis_s1_t axis_front(logic [PIX_W-1:0] idx, logic [CTR_W-1:0] ctr);
    logic [CTR_W:0]   diff;
    logic [CTR_W:0]   ndiff;
    axis_s1_t         res;
    diff    = {1'b0, idx, {FRAC_W{1'b0}}} - {1'b0, ctr};
    ndiff   = ~diff + 1'b1;
    res.neg = diff[CTR_W];
    res.mag = res.neg ? ndiff[MAG_W-1:0] : diff[MAG_W-1:0];
    return res;
  endfunction

  // Apply sign to the truncated magnitude and clamp to the Q23.8 range
  function automatic logic [COORD_W-1:0] sat_coord(axis_s4_t a);
    logic [COORD_W-1:0] res;
    if (a.neg) begin
      if (a.quo >= QUO_W'(COORD_MIN)) res = COORD_MIN;
      else                            res = ~a.quo[COORD_W-1:0] + 1'b1;
    end else begin
      if (a.quo > QUO_W'(COORD_MAX))  res = COORD_MAX;
      else                            res = a.quo[COORD_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers

  logic [INV_W-1:0]   inv_fx_q, inv_fx_d;
  logic [INV_W-1:0]   inv_fy_q, inv_fy_d;
  logic [CTR_W-1:0]   ctr_x_q, ctr_x_d;
  logic [CTR_W-1:0]   ctr_y_q, ctr_y_d;
  logic [DEPTH_W-1:0] min_z_q, min_z_d;
  logic [DEPTH_W-1:0] max_z_q, max_z_d;
  logic               use_mask_q, use_mask_d;

  assign cfg_i.ready = 1'b1;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    inv_fx_d   = inv_fx_q;
    inv_fy_d   = inv_fy_q;
    ctr_x_d    = ctr_x_q;
    ctr_y_d    = ctr_y_q;
    min_z_d    = min_z_q;
    max_z_d    = max_z_q;
    use_mask_d = use_mask_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.addr))
        REG_INV_FOCAL_X:  inv_fx_d   = cfg_i.wdata[INV_W-1:0];
        REG_INV_FOCAL_Y:  inv_fy_d   = cfg_i.wdata[INV_W-1:0];
        REG_CENTRE_X:     ctr_x_d    = cfg_i.wdata[CTR_W-1:0];
        REG_CENTRE_Y:     ctr_y_d    = cfg_i.wdata[CTR_W-1:0];
        REG_MIN_DEPTH_MM: min_z_d    = cfg_i.wdata[DEPTH_W-1:0];
        REG_MAX_DEPTH_MM: max_z_d    = cfg_i.wdata[DEPTH_W-1:0];
        REG_USE_MASK:     use_mask_d = cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q   <= '0;
      inv_fy_q   <= '0;
      ctr_x_q    <= '0;
      ctr_y_q    <= '0;
      min_z_q    <= MIN_DEPTH_RST;
      max_z_q    <= MAX_DEPTH_RST;
      use_mask_q <= 1'b1;
    end else begin
      inv_fx_q   <= inv_fx_d;
      inv_fy_q   <= inv_fy_d;
      ctr_x_q    <= ctr_x_d;
      ctr_y_q    <= ctr_y_d;
      min_z_q    <= min_z_d;
      max_z_q    <= max_z_d;
      use_mask_q <= use_mask_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v1_d;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || pt_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pix_i.ready = en1;

  // Beats are dropped at entry while the intrinsics are unset
  logic intr_ok;
  assign intr_ok = (inv_fx_q != '0) && (inv_fy_q != '0);
  assign v1_d    = pix_i.valid && intr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= v1_d;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pixel checks and distance from the principal point

  axis_s1_t  s1_x_d, s1_y_d, s1_x_q, s1_y_q;
  pix_side_t side1_d, side1_q;
  logic      mask_rej;
  logic      depth_ok;

  always_comb begin
    mask_rej    = use_mask_q && pix_i.mask_valid && (pix_i.mask_value == '0);
    depth_ok    = (pix_i.depth != '0) && (pix_i.depth >= min_z_q) &&
                  (pix_i.depth <= max_z_q);
    side1_d.ok  = depth_ok && !mask_rej;
    side1_d.z   = pix_i.depth;
    s1_x_d      = axis_front(pix_i.pixel_col, ctr_x_q);
    s1_y_d      = axis_front(pix_i.pixel_row, ctr_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_x_q  <= s1_x_d;
      s1_y_q  <= s1_y_d;
      side1_q <= side1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: |d| * z

  axis_s2_t  s2_x_d, s2_y_d, s2_x_q, s2_y_q;
  pix_side_t side2_q;

  always_comb begin
    s2_x_d.neg  = s1_x_q.neg;
    s2_x_d.prod = PROD_W'(s1_x_q.mag) * PROD_W'(side1_q.z);
    s2_y_d.neg  = s1_y_q.neg;
    s2_y_d.prod = PROD_W'(s1_y_q.mag) * PROD_W'(side1_q.z);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_x_q  <= s2_x_d;
      s2_y_q  <= s2_y_d;
      side2_q <= side1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: partial products against the upper and lower reciprocal halves

  axis_s3_t  s3_x_d, s3_y_d, s3_x_q, s3_y_q;
  pix_side_t side3_q;

  always_comb begin
    s3_x_d.neg = s2_x_q.neg;
    s3_x_d.hi  = PART_W'(s2_x_q.prod) * PART_W'(inv_fx_q[INV_W-1:INV_HALF_W]);
    s3_x_d.lo  = PART_W'(s2_x_q.prod) * PART_W'(inv_fx_q[INV_HALF_W-1:0]);
    s3_y_d.neg = s2_y_q.neg;
    s3_y_d.hi  = PART_W'(s2_y_q.prod) * PART_W'(inv_fy_q[INV_W-1:INV_HALF_W]);
    s3_y_d.lo  = PART_W'(s2_y_q.prod) * PART_W'(inv_fy_q[INV_HALF_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_x_q  <= s3_x_d;
      s3_y_q  <= s3_y_d;
      side3_q <= side2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: merge partials, floor of product over 2^32

  axis_s4_t       s4_x_d, s4_y_d, s4_x_q, s4_y_q;
  pix_side_t      side4_q;
  logic [PART_W:0] sum_x, sum_y;

  always_comb begin
    sum_x       = {1'b0, s3_x_q.hi} + (PART_W + 1)'(s3_x_q.lo[PART_W-1:INV_HALF_W]);
    sum_y       = {1'b0, s3_y_q.hi} + (PART_W + 1)'(s3_y_q.lo[PART_W-1:INV_HALF_W]);
    s4_x_d.neg  = s3_x_q.neg;
    s4_x_d.quo  = sum_x[PART_W:INV_HALF_W];
    s4_y_d.neg  = s3_y_q.neg;
    s4_y_d.quo  = sum_y[PART_W:INV_HALF_W];
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_x_q  <= s4_x_d;
      s4_y_q  <= s4_y_d;
      side4_q <= side3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sign, saturation, zeroing of rejected pixels; output register

  logic signed [COORD_W-1:0] px_d, px_q;
  logic signed [COORD_W-1:0] py_d, py_q;
  logic [DEPTH_W-1:0]        pz_d, pz_q;
  logic                      pv_d, pv_q;

  always_comb begin
    px_d = side4_q.ok ? sat_coord(s4_x_q) : '0;
    py_d = side4_q.ok ? sat_coord(s4_y_q) : '0;
    pz_d = side4_q.ok ? side4_q.z : '0;
    pv_d = side4_q.ok;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      pv_q <= pv_d;
    end
  end

  assign pt_o.valid       = v5_q;
  assign pt_o.point_x     = px_q;
  assign pt_o.point_y     = py_q;
  assign pt_o.point_z     = pz_q;
  assign pt_o.point_valid = pv_q;

endmodule

`default_nettype wire

FILE: rtl/dpb_checker.sv
// Port-level checks on the point output of depth_pixel_backprojection.
// Depends on depth_pixel_backprojection_assert.svh and dpb_pkg; bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "depth_pixel_backprojection_assert.svh"

module dpb_checker
  import dpb_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      valid_i,
  input logic                      ready_i,
  input logic signed [COORD_W-1:0] point_x_i,
  input logic signed [COORD_W-1:0] point_y_i,
  input logic [DEPTH_W-1:0]        point_z_i,
  input logic                      point_valid_i
);

  // A stalled beat stays put
  `DPB_ASSERT_NEXT(a_stall_hold, valid_i && !ready_i, valid_i && $stable(point_x_i) && $stable(point_y_i) && $stable(point_z_i) && $stable(point_valid_i))

  // Rejected pixels carry all-zero coordinates
  `DPB_ASSERT_IMPLY(a_reject_zero, valid_i && !point_valid_i, point_x_i == '0 && point_y_i == '0 && point_z_i == '0)

  // A real point never has zero depth
  `DPB_ASSERT_IMPLY(a_point_depth, valid_i && point_valid_i, point_z_i != '0)

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (pt_o.valid),
  .ready_i       (pt_o.ready),
  .point_x_i     (pt_o.point_x),
  .point_y_i     (pt_o.point_y),
  .point_z_i     (pt_o.point_z),
  .point_valid_i (pt_o.point_valid)
);

`default_nettype wire

FILE: bench/tb_depth_pixel_backprojection.sv
// Self-checking bench for depth_pixel_backprojection: directed table, then random pixel phases.
// Depends on dpb_pkg and the channel interfaces in dpb_if.sv; points are checked against a
// local back-projection predictor under random source idling and sink stalls.
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection;
  import dpb_pkg::*;

  localparam int PIPE_DEPTH   = 5;
  localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH + 2;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 180;
  localparam int FULL_W       = CTR_W + DEPTH_W + INV_W;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [MASK_W-1:0]  mask_value;
    logic               mask_valid;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DEPTH_W-1:0] z;
    logic               valid;
  } point_t;

  typedef enum bit {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    pixel_t                beat;
    bit                    typed;
    point_t                want;
  } stim_row_t;

  localparam point_t REJECTED = '0;

  logic clk_i;
  logic rst_ni;

  dpb_cfg_if   cfg ();
  dpb_pixel_if pix ();
  dpb_point_if pt ();

  depth_pixel_backprojection dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix),
    .pt_o   (pt)
  );

  // Register shadow, tracks every accepted config write
  logic [INV_W-1:0]   inv_fx;
  logic [INV_W-1:0]   inv_fy;
  logic [CTR_W-1:0]   ctr_x;
  logic [CTR_W-1:0]   ctr_y;
  logic [DEPTH_W-1:0] near_mm;
  logic [DEPTH_W-1:0] far_mm;
  logic               mask_en;

  point_t pending_points[$];
  int     mismatch_count = 0;
  int     src_idle_pct   = 0;
  int     snk_stall_pct  = 0;

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // One axis: |idx*256 - ctr| * z * inv, truncated, signed, saturated
  function automatic logic [COORD_W-1:0] project_axis(logic [PIX_W-1:0] idx,
                                                      logic [CTR_W-1:0] ctr,
                                                      logic [DEPTH_W-1:0] z,
                                                      logic [INV_W-1:0] inv);
    logic [CTR_W-1:0]         pos;
    logic [CTR_W-1:0]         mag;
    logic [FULL_W-1:0]        full;
    logic [FULL_W-INV_W-1:0]  q;
    bit                       neg;
    pos  = {idx, {FRAC_W{1'b0}}};
    neg  = pos < ctr;
    mag  = neg ? ctr - pos : pos - ctr;
    full = FULL_W'(mag) * FULL_W'(z) * FULL_W'(inv);
    q    = full[FULL_W-1:INV_W];
    if (neg) begin
      if (q >= FULL_W'(COORD_MIN)) return COORD_MIN;
      return -q[COORD_W-1:0];
    end
    if (q > FULL_W'(COORD_MAX)) return COORD_MAX;
    return q[COORD_W-1:0];
  endfunction

  // Returns 0 when the beat yields no point (intrinsics not loaded)
  function automatic bit backproject_pixel(pixel_t p, output point_t pt_out);
    bit keep;
    pt_out = '0;
    if (inv_fx == '0 || inv_fy == '0) return 1'b0;
    keep = !(mask_en && p.mask_valid && p.mask_value == '0) && p.depth != '0 &&
           p.depth >= near_mm && p.depth <= far_mm;
    if (keep) begin
      pt_out.x     = project_axis(p.col, ctr_x, p.depth, inv_fx);
      pt_out.y     = project_axis(p.row, ctr_y, p.depth, inv_fy);
      pt_out.z     = p.depth;
      pt_out.valid = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic pixel_t pixel_beat(int d, int mval, int mok, int u, int v);
    pixel_t p;
    p.depth      = DEPTH_W'(d);
    p.mask_value = MASK_W'(mval);
    p.mask_valid = mok[0];
    p.col        = PIX_W'(u);
    p.row        = PIX_W'(v);
    return p;
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, wdata: data, beat: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t pix_row(pixel_t p);
    stim_row_t r;
    r = '{kind: ROW_PIX, reg_idx: REG_INV_FOCAL_X, wdata: '0, beat: p, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(pixel_t p, point_t w);
    stim_row_t r;
    r       = pix_row(p);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_inv();
    case ($urandom_range(15))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      3, 4:    return $urandom;
      default: return $urandom_range(32'h0100_0000, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_centre();
    case ($urandom_range(4))
      0:       return '0;
      1:       return CFG_DATA_W'(20'hF_FFFF);
      default: return CFG_DATA_W'($urandom_range(20'hF_FFFF));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                 logic [COORD_W-1:0] want);
    $display("%0t ns  point %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Stop sending and let the pipeline empty out
  task automatic settle_pipeline();
    pix.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    settle_pipeline();
    cfg.valid <= 1'b1;
    cfg.addr  <= idx;
    cfg.wdata <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_INV_FOCAL_X:  inv_fx  = data[INV_W-1:0];
      REG_INV_FOCAL_Y:  inv_fy  = data[INV_W-1:0];
      REG_CENTRE_X:     ctr_x   = data[CTR_W-1:0];
      REG_CENTRE_Y:     ctr_y   = data[CTR_W-1:0];
      REG_MIN_DEPTH_MM: near_mm = data[DEPTH_W-1:0];
      REG_MAX_DEPTH_MM: far_mm  = data[DEPTH_W-1:0];
      REG_USE_MASK:     mask_en = data[0];
      default: ;
    endcase
  endtask

  // Drive one pixel beat after a random idle gap; queue what it should produce
  task automatic send_pixel(pixel_t p, bit typed, point_t typed_want);
    point_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.depth      <= p.depth;
    pix.mask_value <= p.mask_value;
    pix.mask_valid <= p.mask_valid;
    pix.pixel_col  <= p.col;
    pix.pixel_row  <= p.row;
    do @(posedge clk_i); while (!pix.ready);
    if (typed) pending_points.push_back(typed_want);
    else if (backproject_pixel(p, pred)) pending_points.push_back(pred);
  endtask

  // Point sink: random backpressure
  initial begin
    pt.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      pt.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Point checker: each accepted beat against the oldest expectation
  always @(posedge clk_i) begin : point_check
    point_t want;
    if (rst_ni && pt.valid && pt.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("beat with nothing pending, x", pt.point_x, '0);
      end else begin
        want = pending_points.pop_front();
        if (pt.point_x !== want.x) report_mismatch("x", pt.point_x, want.x);
        if (pt.point_y !== want.y) report_mismatch("y", pt.point_y, want.y);
        if (pt.point_z !== want.z) report_mismatch("z", COORD_W'(pt.point_z), COORD_W'(want.z));
        if (pt.point_valid !== want.valid)
          report_mismatch("valid", COORD_W'(pt.point_valid), COORD_W'(want.valid));
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t          dir_rows[$];
    pixel_t             beat;
    int                 sel;
    logic [DEPTH_W-1:0] lo;
    logic [DEPTH_W-1:0] hi;
    logic [DEPTH_W-1:0] a;
    logic [DEPTH_W-1:0] b;

    rst_ni         <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.addr       <= REG_INV_FOCAL_X;
    cfg.wdata      <= '0;
    pix.valid      <= 1'b0;
    pix.depth      <= '0;
    pix.mask_value <= '0;
    pix.mask_valid <= 1'b0;
    pix.pixel_col  <= '0;
    pix.pixel_row  <= '0;

    inv_fx  = '0;
    inv_fy  = '0;
    ctr_x   = '0;
    ctr_y   = '0;
    near_mm = MIN_DEPTH_RST;
    far_mm  = MAX_DEPTH_RST;
    mask_en = 1'b1;

    // Directed table: intrinsics unloaded, rejection rules, range edges, saturation
    dir_rows.push_back(pix_row(pixel_beat(1000, 5, 1, 10, 20)));
    dir_rows.push_back(pix_row(pixel_beat(0, 0, 1, 4095, 4095)));
    dir_rows.push_back(cfg_row(REG_INV_FOCAL_X, 32'h0100_0000));
    dir_rows.push_back(pix_row(pixel_beat(500, 1, 1, 100, 100)));
    dir_rows.push_back(cfg_row(REG_INV_FOCAL_Y, 32'h0100_0000));
    dir_rows.push_back(typed_row(pixel_beat(100, 1, 1, 0, 0), '{'0, '0, 16'd100, 1'b1}));
    dir_rows.push_back(typed_row(pixel_beat(2000, 0, 1, 50, 60), REJECTED));
    dir_rows.push_back(typed_row(pixel_beat(0, 7, 1, 50, 60), REJECTED));
    dir_rows.push_back(typed_row(pixel_beat(99, 7, 1, 50, 60), REJECTED));
    dir_rows.push_back(typed_row(pixel_beat(30001, 7, 1, 50, 60), REJECTED));
    dir_rows.push_back(pix_row(pixel_beat(30000, 0, 0, 50, 60)));
    dir_rows.push_back(pix_row(pixel_beat(100, 255, 1, 4095, 4095)));
    dir_rows.push_back(cfg_row(REG_CENTRE_X, 32'd81920));
    dir_rows.push_back(cfg_row(REG_CENTRE_Y, 32'd61440));
    dir_rows.push_back(pix_row(pixel_beat(1500, 3, 1, 0, 0)));
    dir_rows.push_back(pix_row(pixel_beat(1500, 3, 1, 639, 479)));
    dir_rows.push_back(cfg_row(REG_USE_MASK, 32'd0));
    dir_rows.push_back(typed_row(pixel_beat(1500, 0, 1, 320, 240), '{'0, '0, 16'd1500, 1'b1}));
    // inverted range rejects everything
    dir_rows.push_back(cfg_row(REG_MIN_DEPTH_MM, 32'd500));
    dir_rows.push_back(cfg_row(REG_MAX_DEPTH_MM, 32'd400));
    dir_rows.push_back(typed_row(pixel_beat(450, 9, 1, 7, 9), REJECTED));
    dir_rows.push_back(typed_row(pixel_beat(500, 9, 1, 7, 9), REJECTED));
    dir_rows.push_back(typed_row(pixel_beat(400, 9, 1, 7, 9), REJECTED));
    // widest range: zero depth still rejected
    dir_rows.push_back(cfg_row(REG_MIN_DEPTH_MM, 32'd0));
    dir_rows.push_back(cfg_row(REG_MAX_DEPTH_MM, 32'd65535));
    dir_rows.push_back(typed_row(pixel_beat(0, 9, 1, 7, 9), REJECTED));
    dir_rows.push_back(pix_row(pixel_beat(1, 9, 1, 7, 9)));
    dir_rows.push_back(pix_row(pixel_beat(65535, 9, 1, 7, 100)));
    // largest reciprocals and largest x centre: both saturation limits
    dir_rows.push_back(cfg_row(REG_INV_FOCAL_X, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_INV_FOCAL_Y, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_CENTRE_X, 32'h000F_FFFF));
    dir_rows.push_back(cfg_row(REG_CENTRE_Y, 32'd0));
    dir_rows.push_back(typed_row(pixel_beat(65535, 255, 1, 0, 4095),
                                 '{COORD_MIN, COORD_MAX, 16'hFFFF, 1'b1}));
    dir_rows.push_back(pix_row(pixel_beat(65535, 128, 0, 4095, 0)));
    dir_rows.push_back(cfg_row(REG_USE_MASK, 32'd1));
    dir_rows.push_back(typed_row(pixel_beat(65535, 0, 1, 11, 13), REJECTED));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      else send_pixel(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each with fresh registers and an idling pattern set by the phase number
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
        default: begin src_idle_pct = 25; snk_stall_pct = 25; end
      endcase

      write_reg(REG_INV_FOCAL_X, pick_inv());
      write_reg(REG_INV_FOCAL_Y, pick_inv());
      write_reg(REG_CENTRE_X, pick_centre());
      write_reg(REG_CENTRE_Y, pick_centre());
      case ($urandom_range(9))
        0, 1: begin lo = MIN_DEPTH_RST; hi = MAX_DEPTH_RST; end
        2: begin lo = '0; hi = '1; end
        3: begin lo = DEPTH_W'($urandom); hi = lo; end
        4: begin
          hi = DEPTH_W'($urandom_range(60000));
          lo = hi + DEPTH_W'($urandom_range(5000, 1));
        end
        default: begin
          a  = DEPTH_W'($urandom);
          b  = DEPTH_W'($urandom);
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
      endcase
      write_reg(REG_MIN_DEPTH_MM, CFG_DATA_W'(lo));
      write_reg(REG_MAX_DEPTH_MM, CFG_DATA_W'(hi));
      write_reg(REG_USE_MASK, CFG_DATA_W'($urandom_range(3) != 0));

      for (int n = 0; n < PHASE_BEATS; n++) begin
        // hold off mid-phase until every point is out
        if (ph == 1 && n == PHASE_BEATS / 2) settle_pipeline();
        sel = $urandom_range(99);
        if (sel < 70)
          beat.depth = (near_mm <= far_mm) ? DEPTH_W'($urandom_range(far_mm, near_mm))
                                           : DEPTH_W'($urandom);
        else if (sel < 78)
          beat.depth = '0;
        else if (sel < 86)
          case ($urandom_range(3))
            0: beat.depth = near_mm - 1'b1;
            1: beat.depth = near_mm;
            2: beat.depth = far_mm;
            default: beat.depth = far_mm + 1'b1;
          endcase
        else
          beat.depth = DEPTH_W'($urandom);
        beat.mask_value = ($urandom_range(99) < 15) ? '0 : MASK_W'($urandom_range(255, 1));
        beat.mask_valid = ($urandom_range(3) != 0);
        beat.col        = PIX_W'($urandom);
        beat.row        = PIX_W'($urandom);
        send_pixel(beat, 1'b0, REJECTED);
      end
    end

    settle_pipeline();
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
